@@ design/future_frame_holding_table_defines.svh @@
// Assertion macros shared by the checker
`ifndef FUTURE_FRAME_HOLDING_TABLE_DEFINES_SVH
`define FUTURE_FRAME_HOLDING_TABLE_DEFINES_SVH
// Assert a property on the clock, off during reset
`define FFHT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Hold a stalled beat: valid stays high and the payload is unchanged
`define FFHT_HOLD(label, vld, rdy, data, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		vld && !rdy |=> vld && $stable(data)) else $error(msg);
`endif

@@ design/ffht_pkg.sv @@
// Shared types and codes for the frame holding table
package ffht_pkg;
	localparam logic [1:0] CMD_BUFFER  = 2'd0;
	localparam logic [1:0] CMD_ADVANCE = 2'd1;
	localparam logic [1:0] CMD_FENCE   = 2'd2;
	localparam logic [1:0] CMD_RESTART = 2'd3;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_EVICTED  = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_GEN_OK   = 3'd5;
	localparam logic [2:0] ST_GEN_REJ  = 3'd6;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] sequence_req;
		logic [31:0] time_stamp;
		logic [31:0] generation;
		logic [15:0] frame_bytes;
		logic [62:0] arrival_time;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot;
		logic [31:0] out_sequence;
		logic [31:0] out_time_stamp;
		logic [31:0] out_generation;
		logic [15:0] out_frame_bytes;
		logic [62:0] out_arrival_time;
		logic        last;
		logic [31:0] drop_total;
	} out_item_t;

	// Stored descriptor; sequence and generation are also mirrored in the scanner
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ts;
		logic [31:0] gen;
		logic [15:0] size;
		logic [62:0] arrival;
	} entry_t;
endpackage

@@ design/future_frame_holding_table.sv @@
// Future frame holding table: top level with scan sequencer
// Buffer and advance commands scan the key arrays one slot a cycle, then decide
// in a decision state, which registers their first result. Restart, fence and a
// rejected advance answer at the accepting edge. An advance that releases frames
// adds a memory read state and an emit state before its first release; each
// further release waits for the previous beat to leave and rescans. A result
// waits in an output register, and the next beat is taken only once every result
// of the command has gone. The valid bits, the current generation and the drop
// count are flops cleared by reset; descriptor fields live in a one-read-port
// memory. Slot indexes on the port are the low three bits of the slot number.
module future_frame_holding_table import ffht_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_WAIT = 3'd5;

	logic [2:0]       state_q;
	in_item_t         cmd_q;
	logic [SLOTS-1:0] used_q;
	logic [31:0]      cur_gen_q, drop_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    cnt_q;
	logic             dup_q, free_q, vic_q, best_q;
	logic [AW-1:0]    dup_slot_q, free_slot_q, vic_slot_q, best_slot_q;
	logic [31:0]      vic_seq_q, best_seq_q;
	logic [31:0]      kseq_q [SLOTS];
	logic [31:0]      kgen_q [SLOTS];
	logic [31:0]      rseq_s1, rgen_s1;
	logic             rvalid_s1;
	logic [AW-1:0]    rslot_s1;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	entry_t           mem_wdata, mem_rdata;
	logic [31:0]      gen_in;

	assign gen_in    = cmd_q.generation;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign mem_raddr = best_slot_q;

	ffht_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Key arrays: read one entry per cycle at the scan index
	always_ff @(posedge clk) begin
		rseq_s1  <= kseq_q[idx_q[AW-1:0]];
		rgen_s1  <= kgen_q[idx_q[AW-1:0]];
		rslot_s1 <= idx_q[AW-1:0];
		if (mem_we) begin
			kseq_q[mem_waddr] <= mem_wdata.seq;
			kgen_q[mem_waddr] <= mem_wdata.gen;
		end
	end

	logic buf_hit;
	assign buf_hit = (!free_q) ? vic_q && (cmd_q.sequence_req > vic_seq_q) : 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = free_q ? free_slot_q : vic_slot_q;
		mem_wdata = '{seq: cmd_q.sequence_req, ts: cmd_q.time_stamp,
			gen: cmd_q.generation, size: cmd_q.frame_bytes,
			arrival: cmd_q.arrival_time};
		if (state_q == S_DEC && cmd_q.command == CMD_BUFFER && !dup_q && buf_hit)
			mem_we = 1'b1;
	end

	function automatic out_item_t plain(input logic [2:0] st, input logic [AW-1:0] sl,
			input logic [31:0] g, input logic [31:0] d);
		out_item_t o;
		o = '0;
		o.status = st;
		o.slot = 3'(sl);
		o.out_generation = g;
		o.last = 1'b1;
		o.drop_total = d;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			cur_gen_q   <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
			rvalid_s1   <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			rvalid_s1 <= (state_q == S_SCAN) && (idx_q < CW'(SLOTS));
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= in_data;
						idx_q <= '0;
						cnt_q <= '0;
						dup_q <= 1'b0; free_q <= 1'b0; vic_q <= 1'b0; best_q <= 1'b0;
						dup_slot_q <= '0; free_slot_q <= '0; vic_slot_q <= '0;
						best_slot_q <= '0;
						case (in_data.command)
							CMD_RESTART: begin
								used_q <= '0; cur_gen_q <= '0; drop_q <= '0;
								out_q <= plain(ST_GEN_OK, '0, '0, '0);
								out_valid_q <= 1'b1;
							end
							CMD_ADVANCE, CMD_FENCE: begin
								if (in_data.generation < cur_gen_q) begin
									out_q <= plain(ST_GEN_REJ, '0, cur_gen_q, drop_q);
									out_valid_q <= 1'b1;
								end else if (in_data.command == CMD_FENCE) begin
									for (int i = 0; i < SLOTS; i++)
										if (in_data.generation == cur_gen_q ||
												kgen_q[i] < in_data.generation)
											used_q[i] <= 1'b0;
									cur_gen_q <= in_data.generation;
									out_q <= plain(ST_GEN_OK, '0, in_data.generation, drop_q);
									out_valid_q <= 1'b1;
								end else begin
									for (int i = 0; i < SLOTS; i++)
										if (kgen_q[i] < in_data.generation)
											used_q[i] <= 1'b0;
									cur_gen_q <= in_data.generation;
									state_q <= S_SCAN;
								end
							end
							default: state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					if (idx_q < CW'(SLOTS))
						idx_q <= idx_q + 1'b1;
					if (rvalid_s1) begin
						if (used_q[rslot_s1]) begin
							if (rseq_s1 == cmd_q.sequence_req && !dup_q) begin
								dup_q <= 1'b1; dup_slot_q <= rslot_s1;
							end
							if (rgen_s1 == gen_in)
								cnt_q <= cnt_q + 1'b1;
							if (rgen_s1 == gen_in && (!vic_q || rseq_s1 < vic_seq_q)) begin
								vic_q <= 1'b1; vic_slot_q <= rslot_s1; vic_seq_q <= rseq_s1;
							end
							if (rgen_s1 == gen_in && (!best_q || rseq_s1 < best_seq_q)) begin
								best_q <= 1'b1; best_slot_q <= rslot_s1;
								best_seq_q <= rseq_s1;
							end
						end else if (!free_q) begin
							free_q <= 1'b1; free_slot_q <= rslot_s1;
						end
					end
					if (idx_q == CW'(SLOTS) && !rvalid_s1)
						state_q <= S_DEC;
				end
				S_DEC: begin
					if (cmd_q.command == CMD_BUFFER) begin
						if (dup_q)
							out_q <= plain(ST_DUP, dup_slot_q, cur_gen_q, drop_q);
						else if (free_q) begin
							used_q[free_slot_q] <= 1'b1;
							out_q <= plain(ST_STORED, free_slot_q, cur_gen_q, drop_q);
						end else if (buf_hit) begin
							out_q <= plain(ST_EVICTED, vic_slot_q, cur_gen_q, drop_q + 1'b1);
						end else
							out_q <= plain(ST_DROPPED, '0, cur_gen_q, drop_q + 1'b1);
						if (!free_q && !dup_q)
							drop_q <= drop_q + 1'b1;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (!best_q) begin
						out_q <= plain(ST_GEN_OK, '0, cur_gen_q, drop_q);
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else
						state_q <= S_RD;
				end
				S_RD: begin
					// Memory read data for best slot arrives this cycle
					used_q[best_slot_q] <= 1'b0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						// Flag last when the scan found only this frame
						out_q <= '{status: ST_RELEASED, slot: 3'(best_slot_q),
							out_sequence: mem_rdata.seq, out_time_stamp: mem_rdata.ts,
							out_generation: mem_rdata.gen,
							out_frame_bytes: mem_rdata.size,
							out_arrival_time: mem_rdata.arrival,
							last: (cnt_q == CW'(1)), drop_total: drop_q};
						out_valid_q <= 1'b1;
						state_q <= (cnt_q == CW'(1)) ? S_IDLE : S_WAIT;
					end
				end
				S_WAIT: begin
					// Rescan for the next frame once the beat has gone
					if (!out_valid_q || out_ready) begin
						idx_q <= '0; best_q <= 1'b0; cnt_q <= '0;
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/ffht_mem.sv @@
// Descriptor memory: one write port, one registered read port
module ffht_mem import ffht_pkg::*; #(
	parameter int SLOTS = 8,
	parameter int AW = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);
	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ design/ffht_checker.sv @@
// Port-level checker for the frame holding table, bound to the top level
`include "future_frame_holding_table_defines.svh"
module ffht_checker import ffht_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	`FFHT_HOLD(a_out_hold, out_valid, out_ready, out_data, "result beat changed while held")
	`FFHT_ASSERT(a_no_take_busy, out_valid |-> !in_ready, "input taken while result pending")
	`FFHT_ASSERT(a_status_range, out_valid |-> out_data.status != 3'd7, "status code out of range")
endmodule

bind future_frame_holding_table ffht_checker u_ffht_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

@@ tb/tb.sv @@
// Testbench for the future frame holding table: directed table, then random phases
module tb;
	import ffht_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	future_frame_holding_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Mirror of the table
	logic        held      [8];
	logic [31:0] held_seq  [8];
	logic [31:0] held_ts   [8];
	logic [31:0] held_gen  [8];
	logic [15:0] held_size [8];
	logic [62:0] held_arr  [8];
	logic [31:0] play_gen;
	logic [31:0] drops;

	out_item_t fresh_q[$];
	out_item_t want_q[$];
	int        errors = 0;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        hold_req;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 600000);
		$display("Test completed with failures");
		$finish;
	end

	function automatic out_item_t plain_beat(logic [2:0] st, logic [2:0] sl,
			logic [31:0] gen, logic [31:0] drop);
		out_item_t o;
		o = '0;
		o.status = st;
		o.slot = sl;
		o.out_generation = gen;
		o.last = 1'b1;
		o.drop_total = drop;
		return o;
	endfunction

	task automatic free_older();
		for (int i = 0; i < 8; i++)
			if (held[i] && held_gen[i] < play_gen) held[i] = 1'b0;
	endtask

	task automatic clear_table();
		for (int i = 0; i < 8; i++) held[i] = 1'b0;
	endtask

	// Work out the beats one command causes and push them to fresh_q
	task automatic predict_beats(in_item_t it);
		int free_idx;
		int victim;
		int best;
		int n;
		out_item_t o;
		free_idx = -1;
		victim = -1;
		n = 0;
		case (it.command)
			CMD_BUFFER: begin
				for (int i = 0; i < 8; i++)
					if (held[i] && held_seq[i] == it.sequence_req && victim != -2) begin
						fresh_q.push_back(plain_beat(ST_DUP, 3'(i), play_gen, drops));
						victim = -2;
					end
				if (victim == -2) return;
				for (int i = 0; i < 8; i++) begin
					if (!held[i]) begin
						if (free_idx < 0) free_idx = i;
					end else if (held_gen[i] == it.generation &&
							(victim < 0 || held_seq[i] < held_seq[victim])) begin
						victim = i;
					end
				end
				if (free_idx < 0) begin
					drops = drops + 1;
					if (victim < 0 || it.sequence_req <= held_seq[victim]) begin
						fresh_q.push_back(plain_beat(ST_DROPPED, '0, play_gen, drops));
						return;
					end
					free_idx = victim;
				end
				held[free_idx] = 1'b1;
				held_seq[free_idx] = it.sequence_req;
				held_ts[free_idx] = it.time_stamp;
				held_gen[free_idx] = it.generation;
				held_size[free_idx] = it.frame_bytes;
				held_arr[free_idx] = it.arrival_time;
				fresh_q.push_back(plain_beat(victim >= 0 && free_idx == victim ?
					ST_EVICTED : ST_STORED, 3'(free_idx), play_gen, drops));
			end
			CMD_ADVANCE: begin
				if (it.generation < play_gen) begin
					fresh_q.push_back(plain_beat(ST_GEN_REJ, '0, play_gen, drops));
					return;
				end
				play_gen = it.generation;
				free_older();
				forever begin
					best = -1;
					for (int i = 0; i < 8; i++)
						if (held[i] && held_gen[i] == play_gen &&
								(best < 0 || held_seq[i] < held_seq[best]))
							best = i;
					if (best < 0) break;
					o = '0;
					o.status = ST_RELEASED;
					o.slot = 3'(best);
					o.out_sequence = held_seq[best];
					o.out_time_stamp = held_ts[best];
					o.out_generation = held_gen[best];
					o.out_frame_bytes = held_size[best];
					o.out_arrival_time = held_arr[best];
					o.drop_total = drops;
					held[best] = 1'b0;
					fresh_q.push_back(o);
					n++;
				end
				if (n == 0) fresh_q.push_back(plain_beat(ST_GEN_OK, '0, play_gen, drops));
				else fresh_q[fresh_q.size() - 1].last = 1'b1;
			end
			CMD_FENCE: begin
				if (it.generation < play_gen) begin
					fresh_q.push_back(plain_beat(ST_GEN_REJ, '0, play_gen, drops));
					return;
				end
				if (it.generation > play_gen) begin
					play_gen = it.generation;
					free_older();
				end else begin
					clear_table();
				end
				fresh_q.push_back(plain_beat(ST_GEN_OK, '0, play_gen, drops));
			end
			default: begin
				clear_table();
				play_gen = '0;
				drops = '0;
				fresh_q.push_back(plain_beat(ST_GEN_OK, '0, play_gen, drops));
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	// Sample beats at the falling edge: both sides are stable until the next rise
	always @(negedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				report_mismatch("unexpected beat status", out_data.status, 0);
			end else begin
				w = want_q.pop_front();
				if (out_data.status !== w.status)
					report_mismatch("status", out_data.status, w.status);
				if (out_data.slot !== w.slot)
					report_mismatch("slot", out_data.slot, w.slot);
				if (out_data.out_sequence !== w.out_sequence)
					report_mismatch("out_sequence", out_data.out_sequence, w.out_sequence);
				if (out_data.out_time_stamp !== w.out_time_stamp)
					report_mismatch("out_time_stamp", out_data.out_time_stamp,
						w.out_time_stamp);
				if (out_data.out_generation !== w.out_generation)
					report_mismatch("out_generation", out_data.out_generation,
						w.out_generation);
				if (out_data.out_frame_bytes !== w.out_frame_bytes)
					report_mismatch("out_frame_bytes", out_data.out_frame_bytes,
						w.out_frame_bytes);
				if (out_data.out_arrival_time !== w.out_arrival_time)
					report_mismatch("out_arrival_time", out_data.out_arrival_time,
						w.out_arrival_time);
				if (out_data.last !== w.last)
					report_mismatch("last", out_data.last, w.last);
				if (out_data.drop_total !== w.drop_total)
					report_mismatch("drop_total", out_data.drop_total, w.drop_total);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one beat; valid stays high across back-to-back beats
	task automatic send_cmd(in_item_t it, bit typed, out_item_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		predict_beats(it);
		if (typed) begin
			fresh_q.delete();
			want_q.push_back(want);
		end else begin
			while (fresh_q.size() > 0) want_q.push_back(fresh_q.pop_front());
		end
	endtask

	function automatic in_item_t make_cmd(logic [1:0] cmd, logic [31:0] sq, logic [31:0] ts,
			logic [31:0] gen, logic [15:0] sz, logic [62:0] arr);
		in_item_t it;
		it.command = cmd;
		it.sequence_req = sq;
		it.time_stamp = ts;
		it.generation = gen;
		it.frame_bytes = sz;
		it.arrival_time = arr;
		return it;
	endfunction

	task automatic add_row(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
		row_t r;
		r.item = it;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	// Mostly well-formed traffic around the current generation, some noise
	function automatic in_item_t random_cmd();
		in_item_t it;
		int pick;
		logic [31:0] gen;
		pick = $urandom_range(99);
		it = make_cmd(CMD_BUFFER, $urandom_range(40), $urandom, 0, 16'($urandom),
			63'({$urandom, $urandom}));
		gen = play_gen + $urandom_range(2);
		if ($urandom_range(9) == 0 && play_gen != 0) gen = play_gen - 1;
		it.generation = gen;
		if (pick < 10) begin
			it.command = 2'($urandom_range(3));
			it.sequence_req = $urandom;
			it.generation = $urandom;
		end else if (pick < 70) begin
			it.command = CMD_BUFFER;
			if ($urandom_range(1)) it.generation = play_gen;
		end else if (pick < 85) begin
			it.command = CMD_ADVANCE;
		end else if (pick < 96) begin
			it.command = CMD_FENCE;
		end else begin
			it.command = CMD_RESTART;
		end
		return it;
	endfunction

	initial begin
		int idle_pct [4];
		int stall_pct [4];
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		clear_table();
		play_gen = '0;
		drops = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(make_cmd(CMD_RESTART, 0, 0, 0, 0, 0), 1'b1,
			plain_beat(ST_GEN_OK, '0, 0, 0));
		add_row(make_cmd(CMD_BUFFER, 10, 1, 0, 2, 3), 1'b1,
			plain_beat(ST_STORED, '0, 0, 0));
		add_row(make_cmd(CMD_BUFFER, 10, 5, 0, 6, 7), 1'b1,
			plain_beat(ST_DUP, '0, 0, 0));
		add_row(make_cmd(CMD_BUFFER, '1, '1, 0, '1, '1));
		add_row(make_cmd(CMD_BUFFER, 0, 0, 0, 0, 0));
		for (int i = 0; i < 5; i++)
			add_row(make_cmd(CMD_BUFFER, 30 - 4 * i, $urandom, 0, 16'($urandom),
				63'({$urandom, $urandom})));
		// Full table: evict, then drop on a low sequence and on a foreign generation
		add_row(make_cmd(CMD_BUFFER, 5, 11, 0, 12, 13));
		add_row(make_cmd(CMD_BUFFER, 0, 0, 0, 0, 0));
		add_row(make_cmd(CMD_BUFFER, 99, 0, 7, 0, 0));
		add_row(make_cmd(CMD_ADVANCE, 0, 0, 0, 0, 0));
		add_row(make_cmd(CMD_ADVANCE, 0, 0, 0, 0, 0));
		add_row(make_cmd(CMD_FENCE, 0, 0, '1, 0, 0));
		add_row(make_cmd(CMD_ADVANCE, 0, 0, 3, 0, 0), 1'b1,
			plain_beat(ST_GEN_REJ, '0, '1, 3));
		add_row(make_cmd(CMD_BUFFER, 1, 0, '1, 0, 0));
		add_row(make_cmd(CMD_BUFFER, 2, 0, '1, 0, 0));
		add_row(make_cmd(CMD_FENCE, 0, 0, '1, 0, 0));
		add_row(make_cmd(CMD_ADVANCE, 0, 0, '1, 0, 0));
		add_row(make_cmd(CMD_RESTART, 0, 0, 0, 0, 0), 1'b1,
			plain_beat(ST_GEN_OK, '0, 0, 0));
		foreach (rows[i]) send_cmd(rows[i].item, rows[i].typed, rows[i].want);

		idle_pct = '{0, 83, 0, 33};
		stall_pct = '{0, 0, 83, 33};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int k = 0; k < 90; k++) begin
				if (ph == 0 && k == 40) hold_req = 1'b1;
				send_cmd(random_cmd(), 1'b0, '0);
			end
			// Pause the sender until the table has answered everything
			in_valid <= 1'b0;
			wait (want_q.size() == 0);
			@(posedge clk);
		end

		wait (want_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
